// ----- design/bsf_pkg.sv -----
`timescale 1ns / 1ps
// bsf_pkg: types, sizes and helpers shared by the block sample FIFO.
// No dependencies.
package bsf_pkg;

  localparam int BUFFER_COUNT  = 8;     // buffers in the ring, 2..64
  localparam int BUFFER_LENGTH = 32;    // samples per buffer, 1..1024

  localparam int SAMPLE_W   = 13;
  localparam int PLAY_W     = 8;
  localparam int PLAY_SHIFT = 5;

  localparam int IDX_W   = $clog2(BUFFER_COUNT);
  localparam int OFF_W   = (BUFFER_LENGTH > 1) ? $clog2(BUFFER_LENGTH) : 1;
  localparam int DEPTH   = BUFFER_COUNT * BUFFER_LENGTH;
  localparam int ADDR_W  = $clog2(DEPTH);

  typedef enum logic [1:0] {
    BUF_EMPTY   = 2'd0,
    BUF_FILLING = 2'd1,
    BUF_FILLED  = 2'd2
  } buf_state_t;

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] sample_in;
  } req_t;

  typedef struct packed {
    logic              out_valid;
    logic [PLAY_W-1:0] out_value;
    logic              overflow;
  } rsp_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    ring_next = (idx == IDX_W'(BUFFER_COUNT - 1)) ? '0 : IDX_W'(idx + 1'b1);
  endfunction

  function automatic logic [ADDR_W-1:0] buf_addr(input logic [IDX_W-1:0] idx,
                                                 input logic [OFF_W-1:0] off);
    buf_addr = ADDR_W'(ADDR_W'(idx) * ADDR_W'(BUFFER_LENGTH) + ADDR_W'(off));
  endfunction

endpackage

// ----- design/bsf_ram.sv -----
`timescale 1ns / 1ps
// bsf_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/block_sample_fifo.sv -----
`timescale 1ns / 1ps
// block_sample_fifo: ring of sample buffers handing whole blocks to playback.
// Depends on bsf_pkg and bsf_ram.

// A ring of BUFFER_COUNT buffers of BUFFER_LENGTH 13-bit samples, held in one
// RAM with a registered read. A store transaction (cmd 0) writes sample_in at
// the fill position; when a buffer completes it is marked filled and the
// writer moves on. If the next buffer has not been drained yet, overflow is
// raised and stays set: from then on every transaction is answered with
// out_valid 0, out_value 0, overflow 1 and changes nothing. A tick
// transaction (cmd 1) reads one sample from the drain buffer only if that
// buffer is filled, returning bits 12..5; after the last sample the buffer is
// freed. Every request transaction gives exactly one response transaction.
// Throughput is one transaction per cycle while rsp_ready is high: all ring
// bookkeeping is updated in the accept cycle, and the registered RAM read is
// covered by a single stage in front of the response register. A transaction
// waits in that read stage for RAM data, then in the response register.
module block_sample_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bsf_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bsf_pkg::rsp_t rsp
);

  // ring bookkeeping
  bsf_pkg::buf_state_t                 buf_state [bsf_pkg::BUFFER_COUNT];
  bsf_pkg::buf_state_t                 buf_state_next [bsf_pkg::BUFFER_COUNT];
  logic [bsf_pkg::IDX_W-1:0]           fill_index, fill_index_next;
  logic [bsf_pkg::OFF_W-1:0]           fill_offset, fill_offset_next;
  logic [bsf_pkg::IDX_W-1:0]           drain_index, drain_index_next;
  logic [bsf_pkg::OFF_W-1:0]           drain_offset, drain_offset_next;
  logic                                halted, halted_next;

  // read stage: transaction waiting for RAM data
  logic                                pend;
  logic                                pend_hit, pend_hit_next;
  logic                                pend_over;

  logic                                accept;
  logic                                advance;
  logic                                ram_we, ram_re;
  logic [bsf_pkg::ADDR_W-1:0]          ram_waddr, ram_raddr;
  logic [bsf_pkg::SAMPLE_W-1:0]        ram_rdata;
  logic [bsf_pkg::IDX_W-1:0]           fill_ring;

  // response register frees up when empty or being taken
  assign advance   = pend && (!rsp_valid || rsp_ready);
  assign req_ready = !pend || advance;
  assign accept    = req_valid && req_ready;

  assign fill_ring = bsf_pkg::ring_next(fill_index);
  assign ram_waddr = bsf_pkg::buf_addr(fill_index, fill_offset);
  assign ram_raddr = bsf_pkg::buf_addr(drain_index, drain_offset);

  always_comb begin
    buf_state_next    = buf_state;
    fill_index_next   = fill_index;
    fill_offset_next  = fill_offset;
    drain_index_next  = drain_index;
    drain_offset_next = drain_offset;
    halted_next       = halted;
    pend_hit_next     = 1'b0;
    ram_we            = 1'b0;
    ram_re            = 1'b0;

    if (accept && !halted) begin
      if (req.cmd == bsf_pkg::CMD_STORE) begin
        ram_we = 1'b1;
        if (fill_offset == bsf_pkg::OFF_W'(bsf_pkg::BUFFER_LENGTH - 1)) begin
          buf_state_next[fill_index] = bsf_pkg::BUF_FILLED;
          fill_index_next            = fill_ring;
          fill_offset_next           = '0;
          // writer caught up with a buffer still in use
          if (buf_state[fill_ring] != bsf_pkg::BUF_EMPTY) begin
            halted_next = 1'b1;
          end else begin
            buf_state_next[fill_ring] = bsf_pkg::BUF_FILLING;
          end
        end else begin
          fill_offset_next = bsf_pkg::OFF_W'(fill_offset + 1'b1);
        end
      end else if (buf_state[drain_index] == bsf_pkg::BUF_FILLED) begin
        ram_re        = 1'b1;
        pend_hit_next = 1'b1;
        if (drain_offset == bsf_pkg::OFF_W'(bsf_pkg::BUFFER_LENGTH - 1)) begin
          buf_state_next[drain_index] = bsf_pkg::BUF_EMPTY;
          drain_index_next            = bsf_pkg::ring_next(drain_index);
          drain_offset_next           = '0;
        end else begin
          drain_offset_next = bsf_pkg::OFF_W'(drain_offset + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bsf_pkg::BUFFER_COUNT; i++) begin
        buf_state[i] <= bsf_pkg::BUF_EMPTY;
      end
      fill_index   <= '0;
      fill_offset  <= '0;
      drain_index  <= '0;
      drain_offset <= '0;
      halted       <= 1'b0;
      pend         <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      buf_state    <= buf_state_next;
      fill_index   <= fill_index_next;
      fill_offset  <= fill_offset_next;
      drain_index  <= drain_index_next;
      drain_offset <= drain_offset_next;
      halted       <= halted_next;
      if (accept) begin
        pend <= 1'b1;
      end else if (advance) begin
        pend <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload of the read stage and the response register
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_hit  <= pend_hit_next;
      pend_over <= halted_next;
    end
    if (advance) begin
      rsp.out_valid <= pend_hit;
      rsp.out_value <= pend_hit ?
                       ram_rdata[bsf_pkg::PLAY_SHIFT +: bsf_pkg::PLAY_W] : '0;
      rsp.overflow  <= pend_over;
    end
  end

  // read data holds while the read stage stalls: no new read is issued then
  bsf_ram #(
    .WIDTH (bsf_pkg::SAMPLE_W),
    .DEPTH (bsf_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.sample_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
